// File: sv/sorted_key_table_macros.svh
// Assertion helpers for the sorted key table checker.
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/skt_pkg.sv
package skt_pkg;

	typedef enum logic [2:0] {
		CMD_INSERT_SORTED = 3'd0,
		CMD_FIND          = 3'd1,
		CMD_REMOVE        = 3'd2,
		CMD_INSERT_AT     = 3'd3,
		CMD_POP           = 3'd4,
		CMD_ERASE         = 3'd5
	} skt_cmd_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_NOT_FOUND = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_EMPTY     = 3'd3,
		STAT_BAD_RANGE = 3'd4
	} skt_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_SEARCH,
		S_APPLY,
		S_SHIFT,
		S_OUT
	} skt_state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT
	} skt_cell_op_t;

	typedef struct packed {
		skt_cell_op_t op;
		logic         signed_order;
	} skt_cell_ctl_t;

	typedef struct packed {
		logic done;
		logic match;
	} skt_search_res_t;

endpackage

// File: sv/skt_cell.sv
module skt_cell #(
	parameter int KEY_BITS = 32,
	parameter int CW       = 7,
	parameter int IDX      = 0
) (
	input  logic                   clk,
	input  skt_pkg::skt_cell_ctl_t ctl,
	input  logic [CW-1:0]          pos,
	input  logic [KEY_BITS-1:0]    new_key,
	input  logic [KEY_BITS-1:0]    left_key,
	input  logic [KEY_BITS-1:0]    right_key,
	input  logic [KEY_BITS-1:0]    search_key,
	output logic [KEY_BITS-1:0]    key_q,
	output logic                   lt_q,
	output logic                   eq_q,
	output logic [KEY_BITS-1:0]    tap_q
);
	import skt_pkg::*;

	localparam logic [CW-1:0]       MY_IDX  = CW'(IDX);
	localparam logic [KEY_BITS-1:0] TOP_BIT = {1'b1, {(KEY_BITS-1){1'b0}}};

	logic [KEY_BITS-1:0] flip;
	logic [KEY_BITS-1:0] a_ord;
	logic [KEY_BITS-1:0] b_ord;
	logic                at_pos;
	logic                past_pos;

	// Flipping the top bit turns a signed compare into an unsigned one.
	assign flip     = ctl.signed_order ? TOP_BIT : '0;
	assign a_ord    = key_q ^ flip;
	assign b_ord    = search_key ^ flip;
	assign at_pos   = (MY_IDX == pos);
	assign past_pos = (MY_IDX > pos);

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (at_pos) begin
					key_q <= new_key;
				end else if (past_pos) begin
					key_q <= left_key;
				end
			end
			CELL_SHIFT: begin
				if (at_pos || past_pos) begin
					key_q <= right_key;
				end
			end
			default: begin
			end
		endcase
		lt_q  <= (a_ord < b_ord);
		eq_q  <= (a_ord == b_ord);
		tap_q <= at_pos ? key_q : '0;
	end

endmodule

// File: sv/skt_search.sv
module skt_search #(
	parameter int CAPACITY = 64,
	parameter int CW       = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [CW-1:0]            count,
	input  logic [CAPACITY-1:0]      lt_vec,
	input  logic [CAPACITY-1:0]      eq_vec,
	output skt_pkg::skt_search_res_t res,
	output logic [CW-1:0]            idx
);
	import skt_pkg::*;

	localparam int IW = $clog2(CAPACITY);

	logic [CW-1:0] first_q;
	logic [CW-1:0] last_q;
	logic [CW-1:0] first_d;
	logic [CW-1:0] last_d;
	logic [CW-1:0] mid;
	logic          lt;
	logic          eq;

	// One probe of the binary search per cycle against the registered flags.
	always_comb begin
		mid     = first_q + ((last_q - first_q) >> 1);
		lt      = lt_vec[mid[IW-1:0]];
		eq      = eq_vec[mid[IW-1:0]];
		first_d = first_q;
		last_d  = last_q;
		res     = '0;
		idx     = mid;
		if (eq) begin
			res.done  = 1'b1;
			res.match = 1'b1;
		end else if (lt) begin
			if (mid == last_q) begin
				res.done = 1'b1;
				idx      = mid + CW'(1);
			end else begin
				first_d = mid + CW'(1);
			end
		end else begin
			if (mid == first_q) begin
				res.done = 1'b1;
				idx      = first_q;
			end else begin
				last_d = mid - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			last_q  <= '0;
		end else if (start) begin
			first_q <= '0;
			last_q  <= count - CW'(1);
		end else begin
			first_q <= first_d;
			last_q  <= last_d;
		end
	end

endmodule

// File: sv/sorted_key_table.sv
// States from accept to result: insert at APPLY, OUT; pop CMP, APPLY, OUT; erase range
// SHIFT, OUT; sorted insert and find CMP, SEARCH, APPLY, OUT; remove adds SHIFT.
// The search makes at most clog2(CAPACITY) + 1 probes, one probe a cycle over the cells'
// registered compare flags; erase moves the cells one place a cycle. One item at a time.
// Reset clears the entry count and key_order; the key cells are not cleared and no
// clearing pass runs, so the block takes items right after reset.
module sorted_key_table #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // key[31:0], position[39:32], end_position[47:40]
	input  logic [2:0]  s_tuser,   // cmd[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // index[6:0], key_out[38:7], count[45:39], zero pad
	output logic [2:0]  m_tuser    // status[2:0]
);
	import skt_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > 8) ? CW : 8) + 1;

	skt_state_t          state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	logic                order_q;
	logic                m_tvalid_q, m_tvalid_d;

	skt_cmd_t            cmd_q, cmd_d;
	logic [KEY_BITS-1:0] skey_q, skey_d;
	logic [CW-1:0]       pos_q, pos_d;
	logic [CW-1:0]       n_q, n_d;
	logic [CW-1:0]       idx_q, idx_d;
	skt_status_t         status_q, status_d;
	logic [KEY_BITS-1:0] kout_q, kout_d;
	logic                match_q, match_d;

	logic [2:0]          out_status_q;
	logic [6:0]          out_idx_q;
	logic [31:0]         out_kout_q;
	logic [6:0]          out_count_q;
	logic                out_load;

	skt_cell_ctl_t       cell_ctl;
	skt_cell_op_t        cell_op;
	logic                srch_start;
	skt_search_res_t     srch_res;
	logic [CW-1:0]       srch_idx;

	logic [KEY_BITS-1:0] cell_key [CAPACITY];
	logic [KEY_BITS-1:0] cell_tap [CAPACITY];
	logic [KEY_BITS-1:0] left_key [CAPACITY];
	logic [KEY_BITS-1:0] right_key[CAPACITY];
	logic [CAPACITY-1:0] lt_vec;
	logic [CAPACITY-1:0] eq_vec;
	logic [KEY_BITS-1:0] tap_or;

	logic                   accept;
	logic [KEY_BITS+31:0]   key_wide;
	logic [KEY_BITS+31:0]   kout_wide;
	logic [CW+6:0]          idx_wide;
	logic [CW+6:0]          cnt_wide;
	logic signed [XW-1:0]   posx;
	logic signed [XW-1:0]   endx;
	logic signed [XW-1:0]   cntx;
	logic signed [XW-1:0]   span;
	logic                   ins_append;
	logic                   bad_range;
	logic [CW-1:0]          ins_pos;
	logic                   full;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign full     = (count_q == CW'(CAPACITY));

	// Input fields resolved against the current count.
	always_comb begin
		key_wide   = {{KEY_BITS{1'b0}}, s_tdata[31:0]};
		posx       = XW'($signed(s_tdata[39:32]));
		cntx       = $signed({{(XW-CW){1'b0}}, count_q});
		endx       = s_tdata[47] ? cntx : XW'($signed(s_tdata[47:40]));
		ins_append = s_tdata[39] || (posx > cntx);
		bad_range  = s_tdata[39] || (posx >= endx) || (endx > cntx);
		ins_pos    = ins_append ? count_q : posx[CW-1:0];
		span       = endx - posx;
	end

	always_comb begin
		tap_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tap_or = tap_or | cell_tap[i];
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		cmd_d      = cmd_q;
		skey_d     = skey_q;
		pos_d      = pos_q;
		n_d        = n_q;
		idx_d      = idx_q;
		status_d   = status_q;
		kout_d     = kout_q;
		match_d    = match_q;
		cell_op    = CELL_HOLD;
		srch_start = 1'b0;
		out_load   = 1'b0;
		m_tvalid_d = m_tvalid_q && !m_tready;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_d    = skt_cmd_t'(s_tuser);
					skey_d   = key_wide[KEY_BITS-1:0];
					status_d = STAT_OK;
					kout_d   = '0;
					idx_d    = '0;
					pos_d    = '0;
					match_d  = 1'b0;
					case (skt_cmd_t'(s_tuser))
						CMD_INSERT_SORTED, CMD_FIND, CMD_REMOVE: begin
							state_d = (count_q == '0) ? S_APPLY : S_CMP;
						end
						CMD_INSERT_AT: begin
							pos_d   = ins_pos;
							idx_d   = ins_pos;
							state_d = S_APPLY;
						end
						CMD_POP: begin
							if (count_q == '0) begin
								status_d = STAT_EMPTY;
								state_d  = S_OUT;
							end else begin
								pos_d   = count_q - CW'(1);
								idx_d   = count_q - CW'(1);
								state_d = S_CMP;
							end
						end
						CMD_ERASE: begin
							if (bad_range) begin
								status_d = STAT_BAD_RANGE;
								state_d  = S_OUT;
							end else begin
								pos_d   = posx[CW-1:0];
								idx_d   = posx[CW-1:0];
								n_d     = span[CW-1:0];
								state_d = S_SHIFT;
							end
						end
						default: begin
							status_d = STAT_BAD_RANGE;
							state_d  = S_OUT;
						end
					endcase
				end
			end
			S_CMP: begin
				// The cells register their compare flags and pop tap during this cycle.
				if (cmd_q == CMD_POP) begin
					state_d = S_APPLY;
				end else begin
					srch_start = 1'b1;
					state_d    = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (srch_res.done) begin
					pos_d   = srch_idx;
					idx_d   = srch_idx;
					match_d = srch_res.match;
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				state_d = S_OUT;
				case (cmd_q)
					CMD_INSERT_SORTED, CMD_INSERT_AT: begin
						if (full) begin
							status_d = STAT_FULL;
						end else begin
							cell_op = CELL_INSERT;
							count_d = count_q + CW'(1);
						end
					end
					CMD_FIND: begin
						if (match_q) begin
							kout_d = skey_q;
						end else begin
							status_d = STAT_NOT_FOUND;
						end
					end
					CMD_REMOVE: begin
						if (match_q) begin
							kout_d  = skey_q;
							n_d     = CW'(1);
							state_d = S_SHIFT;
						end else begin
							status_d = STAT_NOT_FOUND;
						end
					end
					CMD_POP: begin
						kout_d  = tap_or;
						count_d = count_q - CW'(1);
					end
					default: begin
						status_d = STAT_BAD_RANGE;
					end
				endcase
			end
			S_SHIFT: begin
				cell_op = CELL_SHIFT;
				count_d = count_q - CW'(1);
				n_d     = n_q - CW'(1);
				if (n_q == CW'(1)) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load   = 1'b1;
					m_tvalid_d = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			order_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			m_tvalid_q <= m_tvalid_d;
			if (cfg_we) begin
				order_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		skey_q   <= skey_d;
		pos_q    <= pos_d;
		n_q      <= n_d;
		idx_q    <= idx_d;
		status_q <= status_d;
		kout_q   <= kout_d;
		match_q  <= match_d;
		if (out_load) begin
			out_status_q <= status_q;
			out_idx_q    <= idx_wide[6:0];
			out_kout_q   <= kout_wide[31:0];
			out_count_q  <= cnt_wide[6:0];
		end
	end

	assign kout_wide = {32'b0, kout_q};
	assign idx_wide  = {7'b0, idx_q};
	assign cnt_wide  = {7'b0, count_q};

	assign cell_ctl.op           = cell_op;
	assign cell_ctl.signed_order = order_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_key[i] = skey_q;
		end else begin : g_inner
			assign left_key[i] = cell_key[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_key[i] = cell_key[i];
		end else begin : g_body
			assign right_key[i] = cell_key[i+1];
		end

		skt_cell #(
			.KEY_BITS(KEY_BITS),
			.CW      (CW),
			.IDX     (i)
		) u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.pos       (pos_q),
			.new_key   (skey_q),
			.left_key  (left_key[i]),
			.right_key (right_key[i]),
			.search_key(skey_q),
			.key_q     (cell_key[i]),
			.lt_q      (lt_vec[i]),
			.eq_q      (eq_vec[i]),
			.tap_q     (cell_tap[i])
		);
	end

	skt_search #(
		.CAPACITY(CAPACITY),
		.CW      (CW)
	) u_search (
		.clk   (clk),
		.arst_n(arst_n),
		.start (srch_start),
		.count (count_q),
		.lt_vec(lt_vec),
		.eq_vec(eq_vec),
		.res   (srch_res),
		.idx   (srch_idx)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {2'b0, out_count_q, out_kout_q, out_idx_q};

endmodule

// File: sv/skt_checker.sv
`include "sorted_key_table_macros.svh"

module skt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [2:0]  m_tuser
);
	import skt_pkg::*;

	// A stalled result must hold still.
	`SKT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// The block works on one item at a time, so it cannot take two in a row.
	`SKT_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready, "item accepted while busy")

	// Pop on an empty table reports zero index, key and count.
	`SKT_ASSERT_IMPLY(a_empty_zero, clk, arst_n, m_tvalid && (m_tuser == STAT_EMPTY), m_tdata[45:0] == 46'd0, "empty result not zero")

	// A rejected range reports zero index and key.
	`SKT_ASSERT_IMPLY(a_bad_range_zero, clk, arst_n, m_tvalid && (m_tuser == STAT_BAD_RANGE), m_tdata[38:0] == 39'd0, "bad range result not zero")

endmodule

bind sorted_key_table skt_checker u_skt_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// File: sim/tb_sorted_key_table.sv
`timescale 1ns / 1ps

module tb_sorted_key_table;
	import skt_pkg::*;

	localparam int CAPACITY = 64;
	localparam int KEY_BITS = 32;
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;
	localparam int PHASES = 4;
	localparam int PHASE_ITEMS = 133;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES = 100;
	localparam int N_DIRECTED = 25;

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  index;
		logic [31:0] key_out;
		logic [6:0]  count;
	} table_result_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] key;
		logic [7:0]  pos;
		logic [7:0]  endp;
		logic        typed;
		logic [2:0]  want_status;
		logic [6:0]  want_index;
		logic [31:0] want_key;
		logic [6:0]  want_count;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // key[31:0], position[39:32], end_position[47:40]
	logic [2:0]  s_tuser;   // cmd[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // index[6:0], key_out[38:7], count[45:39], zero pad
	logic [2:0]  m_tuser;   // status[2:0]

	table_result_t pending_results[$];
	logic [31:0]   key_store [0:CAPACITY-1];
	int            key_count;
	bit            signed_keys;
	int            error_count;
	bit            sender_burst;
	bit            receiver_burst;

	sorted_key_table #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Flipping the top bit maps signed order onto unsigned order.
	function automatic logic [31:0] order_value(input logic [31:0] k);
		return signed_keys ? {~k[31], k[30:0]} : k;
	endfunction

	function automatic int locate_key(input logic [31:0] k, output bit hit);
		int lo;
		int hi;
		int mid;
		hit = 1'b0;
		if (key_count <= 0)
			return 0;
		lo = 0;
		hi = key_count - 1;
		forever begin
			mid = lo + (hi - lo) / 2;
			if (order_value(key_store[mid]) < order_value(k)) begin
				if (mid + 1 > hi)
					return mid + 1;
				lo = mid + 1;
			end else if (order_value(key_store[mid]) > order_value(k)) begin
				if (mid - 1 < lo)
					return lo;
				hi = mid - 1;
			end else begin
				hit = 1'b1;
				return mid;
			end
		end
	endfunction

	function automatic void put_entry(input int where, input logic [31:0] k);
		for (int i = key_count; i > where; i--)
			key_store[i] = key_store[i - 1];
		key_store[where] = k;
		key_count++;
	endfunction

	function automatic void drop_entries(input int first, input int stop);
		for (int i = first; i < key_count - (stop - first); i++)
			key_store[i] = key_store[i + stop - first];
		key_count -= stop - first;
	endfunction

	function automatic table_result_t apply_command(input logic [2:0] cmd, input logic [31:0] k,
			input logic signed [7:0] pos8, input logic signed [7:0] end8);
		table_result_t res;
		int where;
		int first;
		int stop;
		bit hit;
		res = '0;
		res.status = STAT_OK;
		where = 0;
		case (cmd)
			CMD_INSERT_SORTED: begin
				where = locate_key(k, hit);
				if (key_count >= CAPACITY)
					res.status = STAT_FULL;
				else
					put_entry(where, k);
			end
			CMD_FIND, CMD_REMOVE: begin
				where = locate_key(k, hit);
				if (!hit) begin
					res.status = STAT_NOT_FOUND;
				end else begin
					res.key_out = key_store[where];
					if (cmd == CMD_REMOVE)
						drop_entries(where, where + 1);
				end
			end
			CMD_INSERT_AT: begin
				where = pos8;
				if (where < 0 || where > key_count)
					where = key_count;
				if (key_count >= CAPACITY)
					res.status = STAT_FULL;
				else
					put_entry(where, k);
			end
			CMD_POP: begin
				if (key_count == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					key_count--;
					where = key_count;
					res.key_out = key_store[key_count];
				end
			end
			CMD_ERASE: begin
				first = pos8;
				stop = end8;
				if (stop < 0)
					stop = key_count;
				if (first < 0 || first >= stop || stop > key_count) begin
					res.status = STAT_BAD_RANGE;
				end else begin
					where = first;
					drop_entries(first, stop);
				end
			end
			default: res.status = STAT_BAD_RANGE;
		endcase
		res.index = where[6:0];
		res.count = key_count[6:0];
		return res;
	endfunction

	// Half of the keys repeat a stored one so that finds and removes hit.
	function automatic logic [31:0] pick_key();
		int roll;
		roll = $urandom_range(0, 19);
		if (key_count > 0 && roll < 10)
			return key_store[$urandom_range(0, key_count - 1)];
		case (roll)
			10: return 32'h0000_0000;
			11: return 32'hFFFF_FFFF;
			12: return 32'h8000_0000;
			13: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input logic [2:0] cmd, input logic [31:0] k, input logic [7:0] pos,
			input logic [7:0] endp, input bit typed, input table_result_t want);
		int gap;
		table_result_t predicted;
		if ($urandom_range(0, 39) == 0)
			sender_burst = !sender_burst;
		gap = sender_burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {endp, pos, k};
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		predicted = apply_command(cmd, k, pos, endp);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0h data %0h",
					$time, m_tuser, m_tdata);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(m_tuser));
				check_field("index", 32'(want.index), 32'(m_tdata[6:0]));
				check_field("key_out", want.key_out, m_tdata[38:7]);
				check_field("count", 32'(want.count), 32'(m_tdata[45:39]));
			end
		end
	end

	// Result side: random stalls, bursts with none, and two long hold-offs that back
	// the block up while items keep being offered.
	initial begin
		int stall;
		int taken;
		m_tready = 1'b0;
		taken = 0;
		receiver_burst = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		m_tready <= 1'b1;
		forever begin
			do @(posedge clk); while (!m_tvalid);
			taken++;
			if ($urandom_range(0, 29) == 0)
				receiver_burst = !receiver_burst;
			if (taken == 150 || taken == 400)
				stall = HOLD_OFF_CYCLES;
			else
				stall = receiver_burst ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		stim_row_t     directed_rows [0:N_DIRECTED-1];
		logic [2:0]    cmd;
		logic [31:0]   k;
		logic [7:0]    pos;
		logic [7:0]    endp;
		int            pick;
		int            first;
		int            span;
		bit            noise;
		bit            filling;

		directed_rows = '{
			'{CMD_POP, 32'h0, 8'd0, 8'd0, 1'b1, STAT_EMPTY, 7'd0, 32'd0, 7'd0},
			'{CMD_FIND, 32'h5, 8'd0, 8'd0, 1'b1, STAT_NOT_FOUND, 7'd0, 32'd0, 7'd0},
			'{CMD_REMOVE, 32'h5, 8'd0, 8'd0, 1'b1, STAT_NOT_FOUND, 7'd0, 32'd0, 7'd0},
			'{CMD_ERASE, 32'h0, 8'd0, 8'hFF, 1'b1, STAT_BAD_RANGE, 7'd0, 32'd0, 7'd0},
			'{CMD_SPARE_6, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, STAT_BAD_RANGE, 7'd0, 32'd0, 7'd0},
			'{CMD_SPARE_7, 32'h0, 8'd0, 8'd0, 1'b1, STAT_BAD_RANGE, 7'd0, 32'd0, 7'd0},
			'{CMD_INSERT_SORTED, 32'hFFFF_FFFF, 8'd0, 8'd0, 1'b1, STAT_OK, 7'd0, 32'd0, 7'd1},
			'{CMD_INSERT_SORTED, 32'h0, 8'd0, 8'd0, 1'b1, STAT_OK, 7'd0, 32'd0, 7'd2},
			'{CMD_INSERT_SORTED, 32'h8000_0000, 8'd0, 8'd0, 1'b0, STAT_OK, 7'd0, 32'd0, 7'd0},
			'{CMD_INSERT_SORTED, 32'h7FFF_FFFF, 8'd0, 8'd0, 1'b0, STAT_OK, 7'd0, 32'd0, 7'd0},
			'{CMD_FIND, 32'hFFFF_FFFF, 8'd0, 8'd0, 1'b0, STAT_OK, 7'd0, 32'd0, 7'd0},
			// Appends: a negative position and one beyond the count.
			'{CMD_INSERT_AT, 32'h1234_5678, 8'hFF, 8'd0, 1'b0, STAT_OK, 7'd0, 32'd0, 7'd0},
			'{CMD_INSERT_AT, 32'h0000_FFFF, 8'd64, 8'd0, 1'b0, STAT_OK, 7'd0, 32'd0, 7'd0},
			'{CMD_INSERT_AT, 32'hAAAA_AAAA, 8'd0, 8'd0, 1'b0, STAT_OK, 7'd0, 32'd0, 7'd0},
			'{CMD_INSERT_AT, 32'h5555_5555, 8'h80, 8'd0, 1'b0, STAT_OK, 7'd0, 32'd0, 7'd0},
			// Bad ranges: start past the end, end past the count, negative start.
			'{CMD_ERASE, 32'h0, 8'h7F, 8'hFF, 1'b1, STAT_BAD_RANGE, 7'd0, 32'd0, 7'd8},
			'{CMD_ERASE, 32'h0, 8'd2, 8'd100, 1'b1, STAT_BAD_RANGE, 7'd0, 32'd0, 7'd8},
			'{CMD_ERASE, 32'h0, 8'hFF, 8'd3, 1'b1, STAT_BAD_RANGE, 7'd0, 32'd0, 7'd8},
			'{CMD_ERASE, 32'h0, 8'd1, 8'd3, 1'b0, STAT_OK, 7'd0, 32'd0, 7'd0},
			'{CMD_REMOVE, 32'hAAAA_AAAA, 8'd0, 8'd0, 1'b0, STAT_OK, 7'd0, 32'd0, 7'd0},
			'{CMD_REMOVE, 32'h7FFF_FFFF, 8'd0, 8'd0, 1'b0, STAT_OK, 7'd0, 32'd0, 7'd0},
			'{CMD_FIND, 32'h8000_0000, 8'd0, 8'd0, 1'b0, STAT_OK, 7'd0, 32'd0, 7'd0},
			'{CMD_POP, 32'h0, 8'd0, 8'd0, 1'b0, STAT_OK, 7'd0, 32'd0, 7'd0},
			'{CMD_ERASE, 32'h0, 8'd0, 8'hFF, 1'b0, STAT_OK, 7'd0, 32'd0, 7'd0},
			'{CMD_POP, 32'h0, 8'd0, 8'd0, 1'b1, STAT_EMPTY, 7'd0, 32'd0, 7'd0}
		};

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		key_count = 0;
		signed_keys = 1'b0;
		error_count = 0;
		sender_burst = 1'b0;
		filling = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < N_DIRECTED; r++)
			send_item(directed_rows[r].cmd, directed_rows[r].key, directed_rows[r].pos,
				directed_rows[r].endp, directed_rows[r].typed,
				'{directed_rows[r].want_status, directed_rows[r].want_index,
				directed_rows[r].want_key, directed_rows[r].want_count});

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_for_results();
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= ~phase[0];
			@(negedge clk);
			cfg_we <= 1'b0;
			signed_keys = ~phase[0];

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 2 && n == 60)
					wait_for_results();
				// Sweep the table between full and empty so both ends get exercised.
				if (filling && key_count >= CAPACITY && $urandom_range(0, 5) == 0)
					filling = 1'b0;
				else if (!filling && key_count == 0 && $urandom_range(0, 2) == 0)
					filling = 1'b1;
				pick = $urandom_range(0, 99);
				k = pick_key();
				pos = 8'($urandom);
				endp = 8'($urandom);
				if (filling) begin
					noise = pick >= 95;
					cmd = pick < 45 ? CMD_INSERT_SORTED : pick < 60 ? CMD_INSERT_AT :
						pick < 75 ? CMD_FIND : pick < 85 ? CMD_REMOVE : pick < 90 ? CMD_POP :
						pick < 95 ? CMD_ERASE : 3'($urandom_range(0, 7));
				end else begin
					noise = pick >= 93;
					cmd = pick < 10 ? CMD_INSERT_SORTED : pick < 15 ? CMD_INSERT_AT :
						pick < 35 ? CMD_FIND : pick < 60 ? CMD_REMOVE : pick < 80 ? CMD_POP :
						pick < 93 ? CMD_ERASE : 3'($urandom_range(0, 7));
				end
				if (!noise && cmd == CMD_INSERT_AT) begin
					span = $urandom_range(0, 9);
					if (span < 7)
						pos = 8'($urandom_range(0, key_count));
					else if (span < 9)
						pos = 8'hFF;
				end
				if (!noise && cmd == CMD_ERASE && key_count > 0) begin
					first = $urandom_range(0, key_count - 1);
					span = $urandom_range(1, (key_count - first < 4) ? key_count - first : 4);
					pos = 8'(first);
					endp = ($urandom_range(0, 6) == 0) ? 8'hFF : 8'(first + span);
				end
				send_item(cmd, k, pos, endp, 1'b0, '0);
			end
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
